// ===== sv/bthk_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded top-k heap package
// Sizes, register indexes, command codes, sequencer states and the ranking and
// capacity-clipping helpers shared by the heap unit.
// ----------------------------------------------------------------------------
package bthk_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8;
  localparam int CAP_RESET   = (MAX_ENTRIES < 1024) ? MAX_ENTRIES : 1024;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_ORDER = 1'b1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_FULL_CMP,
    ST_POP_LAST,
    ST_POP_ROOT,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_EMIT
  } bthk_state_t;

  // True when a must sit nearer the root than b.
  function automatic logic bthk_above(input logic ord,
                                      input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
    if (ord) begin
      return $signed(b) < $signed(a);
    end
    return $signed(a) < $signed(b);
  endfunction

  // A capacity of zero becomes one, and anything above the store depth is clipped.
  function automatic logic [CNT_W-1:0] bthk_limit_cap(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return CNT_W'(1);
    end
    if (w > 32'(MAX_ENTRIES)) begin
      return CNT_W'(MAX_ENTRIES);
    end
    return CNT_W'(w);
  endfunction

endpackage

// ===== sv/bthk_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bthk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bounded_top_k_heap_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded top-k heap unit
// Keeps the k best signed values seen in a binary heap held in one RAM, with
// push, conditional root replacement when full, and pop of the root.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: value; tuser: command (0 push, 1 pop)
//  m_axis    out        tdata: popped_value, entries_left; tuser: was_empty
//  cfg       in         write of capacity (index 0) or heap_order (index 1)
//
// A push into a non-full heap climbs with one RAM read and one compare per level
// and writes the value where it stops. A pop reads the last entry and then the
// root, then descends with two child reads per level sharing the single read
// port, and ends in the emit state. A push into a full heap checks the root
// first, then runs a pop-style descent and a climb when the value is kept. The
// RAM is not cleared at reset, as only entries below the count are ever read.
// A stalled result waits in the output register while pushes go on; a second
// pop waits at its end until the first is taken.
module bounded_top_k_heap_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bthk_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // [31:0] value
  input  logic                              s_axis_tuser,  // [0] command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bthk_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,  // [31:0] popped_value,
                                                           // [42:32] entries_left
  output logic                              m_axis_tuser,  // [0] was_empty
  input  logic                              cfg_we,
  input  logic [bthk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bthk_pkg::CFG_W-1:0]        cfg_data
);

  import bthk_pkg::*;

  bthk_state_t       state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cap;
  logic              order;
  logic              do_insert;
  logic [ADDR_W-1:0] pos;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] lval;
  logic [DATA_W-1:0] res_value;
  logic              res_empty;
  logic [CNT_W-1:0]  res_left;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_empty;
  logic [CNT_W-1:0]  out_left;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              in_fire;
  logic              cmd_pop;
  logic [DATA_W-1:0] in_value;
  logic [CNT_W-1:0]  cnt_m1;
  logic              not_full;
  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  lidx;
  logic [IDX_W-1:0]  ridx;
  logic              l_ok;
  logic              r_ok;
  logic              up_move;
  logic              bl;
  logic              br;
  logic [DATA_W-1:0] best_val;
  logic              emit_free;

  bthk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cmd_pop   = (s_axis_tuser == CMD_POP);
  assign in_value  = s_axis_tdata[DATA_W-1:0];
  assign cnt_m1    = count - CNT_W'(1);
  assign not_full  = count < cap;
  assign parent    = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign lidx      = IDX_W'({pos, 1'b1});
  assign ridx      = IDX_W'({pos, 1'b0}) + IDX_W'(2);
  assign l_ok      = lidx < IDX_W'(count);
  assign r_ok      = ridx < IDX_W'(count);
  assign up_move   = bthk_above(order, val, ram_rdata);
  assign bl        = bthk_above(order, lval, val);
  assign best_val  = bl ? lval : val;
  assign br        = r_ok && bthk_above(order, ram_rdata, best_val);
  assign emit_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_pop) begin
            state_next = (count == '0) ? ST_EMIT : ST_POP_LAST;
          end else begin
            state_next = not_full ? ST_UP : ST_FULL_CMP;
          end
        end
      end
      ST_UP:       state_next = (pos == '0) ? ST_IDLE : ST_UP_CMP;
      ST_UP_CMP:   state_next = up_move ? ST_UP : ST_IDLE;
      ST_FULL_CMP: state_next = bthk_above(order, ram_rdata, push_val) ? ST_POP_LAST : ST_IDLE;
      ST_POP_LAST: state_next = ST_POP_ROOT;
      ST_POP_ROOT: state_next = ST_DN;
      ST_DN: begin
        if (l_ok) begin
          state_next = ST_DN_L;
        end else begin
          state_next = do_insert ? ST_UP : ST_EMIT;
        end
      end
      ST_DN_L:     state_next = ST_DN_R;
      ST_DN_R: begin
        if (br || bl) begin
          state_next = ST_DN;
        end else begin
          state_next = do_insert ? ST_UP : ST_EMIT;
        end
      end
      ST_EMIT:     state_next = emit_free ? ST_IDLE : ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = pos;
    ram_wdata     = val;
    ram_raddr     = '0;
    case (state)
      ST_IDLE:     ram_raddr = cmd_pop ? cnt_m1[ADDR_W-1:0] : '0;
      ST_UP: begin
        if (pos != '0) begin
          ram_raddr = parent;
        end else begin
          ram_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = up_move ? ram_rdata : val;
      end
      ST_FULL_CMP: ram_raddr = cnt_m1[ADDR_W-1:0];
      ST_POP_LAST: ram_raddr = '0;
      ST_DN: begin
        if (l_ok) begin
          ram_raddr = lidx[ADDR_W-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      ST_DN_L:     ram_raddr = ridx[ADDR_W-1:0];
      ST_DN_R: begin
        ram_we    = 1'b1;
        ram_wdata = br ? ram_rdata : best_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap       <= CNT_W'(CAP_RESET);
      order     <= 1'b0;
      do_insert <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: begin
            if (count == '0) begin
              cap <= bthk_limit_cap(cfg_data);
            end
          end
          REG_HEAP_ORDER: order <= cfg_data[0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            do_insert <= 1'b0;
            if (cmd_pop) begin
              if (count == '0) begin
                res_value <= '1;
                res_empty <= 1'b1;
                res_left  <= '0;
              end else begin
                count <= cnt_m1;
              end
            end else begin
              val      <= in_value;
              push_val <= in_value;
              pos      <= count[ADDR_W-1:0];
              if (not_full) begin
                count <= count + CNT_W'(1);
              end
            end
          end
        end
        ST_UP_CMP: begin
          if (up_move) begin
            pos <= parent;
          end
        end
        ST_FULL_CMP: begin
          if (bthk_above(order, ram_rdata, push_val)) begin
            count     <= cnt_m1;
            do_insert <= 1'b1;
          end
        end
        ST_POP_LAST: val <= ram_rdata;
        ST_POP_ROOT: begin
          res_value <= ram_rdata;
          res_empty <= 1'b0;
          res_left  <= count;
          pos       <= '0;
        end
        ST_DN: begin
          if (!l_ok && do_insert) begin
            val   <= push_val;
            pos   <= count[ADDR_W-1:0];
            count <= count + CNT_W'(1);
          end
        end
        ST_DN_L: lval <= ram_rdata;
        ST_DN_R: begin
          if (br) begin
            pos <= ridx[ADDR_W-1:0];
          end else if (bl) begin
            pos <= lidx[ADDR_W-1:0];
          end else if (do_insert) begin
            val   <= push_val;
            pos   <= count[ADDR_W-1:0];
            count <= count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase

      if (state == ST_EMIT && emit_free) begin
        out_valid <= 1'b1;
        out_value <= res_value;
        out_empty <= res_empty;
        out_left  <= res_left;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_empty;
  assign m_axis_tdata  = {{(TDATA_OUT_W - DATA_W - CNT_W){1'b0}}, out_left, out_value};

  a_count_within_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("entry count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !cmd_pop && not_full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("push into non-full heap did not add an entry");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_value == '1 && out_left == '0))
    else $error("empty pop result carries wrong fields");

endmodule

// ===== verif/bounded_top_k_heap_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Bounded top-k heap unit testbench
// Drives push and pop commands through the input stream and checks every pop
// result against a behavioural heap kept in the testbench. It starts with a
// short directed sequence covering the value extremes, an empty pop, equal and
// dropped values in a full heap, a clipped capacity, an ignored capacity write
// and an order change on a non-empty heap. It then runs random phases under
// varied capacity and order settings, with bursty input, random output stalls
// and long output hold-offs in every fifth phase.
// ----------------------------------------------------------------------------
module bounded_top_k_heap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bthk_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 500;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              empty;
    logic [CNT_W-1:0]  left;
  } pop_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [31:0] value
  logic                   s_axis_tuser = 1'b0; // [0] command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // [31:0] popped_value, [42:32] entries_left
  logic                   m_axis_tuser;        // [0] was_empty
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  bounded_top_k_heap_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  heap_cmd_t   pending_cmds[$];
  pop_result_t expected_pops[$];
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  int          hold_requests = 0;
  logic        in_took = 1'b0;

  // Behavioural copy of the heap and its settings.
  logic [DATA_W-1:0] heap_mem [0:MAX_ENTRIES-1];
  int unsigned       heap_count;
  int unsigned       heap_cap;
  logic              heap_is_max;

  function automatic int unsigned clip_capacity(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MAX_ENTRIES) begin
      return MAX_ENTRIES;
    end
    return int'(v);
  endfunction

  function automatic bit outranks(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    if (heap_is_max) begin
      return $signed(a) > $signed(b);
    end
    return $signed(a) < $signed(b);
  endfunction

  function automatic void swap_slots(input int unsigned i, input int unsigned j);
    logic [DATA_W-1:0] t;
    t = heap_mem[i];
    heap_mem[i] = heap_mem[j];
    heap_mem[j] = t;
  endfunction

  function automatic void climb(input int unsigned start);
    int unsigned pos;
    int unsigned up;
    pos = start;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!outranks(heap_mem[pos], heap_mem[up])) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  function automatic void descend(input int unsigned start);
    int unsigned pos;
    int unsigned best;
    int unsigned l;
    int unsigned r;
    pos = start;
    while (pos < heap_count) begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < heap_count && outranks(heap_mem[l], heap_mem[best])) best = l;
      if (r < heap_count && outranks(heap_mem[r], heap_mem[best])) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic logic [DATA_W-1:0] remove_root();
    heap_count = heap_count - 1;
    swap_slots(0, heap_count);
    descend(0);
    return heap_mem[heap_count];
  endfunction

  function automatic void add_value(input logic [DATA_W-1:0] v);
    heap_mem[heap_count] = v;
    heap_count = heap_count + 1;
    climb(heap_count - 1);
  endfunction

  // Applies one accepted command and, for a pop, queues the result that it must give.
  function automatic void heap_mirror_step(input heap_cmd_t it);
    pop_result_t res;
    if (it.cmd == CMD_PUSH) begin
      if (heap_count < heap_cap) begin
        add_value(it.value);
      end else if (heap_count > 0 && outranks(heap_mem[0], it.value)) begin
        void'(remove_root());
        add_value(it.value);
      end
      return;
    end
    if (heap_count == 0) begin
      res.value = '1;
      res.empty = 1'b1;
      res.left  = '0;
    end else begin
      res.value = remove_root();
      res.empty = 1'b0;
      res.left  = CNT_W'(heap_count);
    end
    expected_pops.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    pop_result_t got;
    pop_result_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[DATA_W-1:0];
        got.left  = m_axis_tdata[DATA_W +: CNT_W];
        got.empty = m_axis_tuser;
        if (expected_pops.size() == 0) begin
          report_mismatch("result with nothing expected", got.value, '0);
        end else begin
          want = expected_pops.pop_front();
          if (got.value !== want.value) report_mismatch("popped_value", got.value, want.value);
          if (got.empty !== want.empty) begin
            report_mismatch("was_empty", DATA_W'(got.empty), DATA_W'(want.empty));
          end
          if (got.left !== want.left) begin
            report_mismatch("entries_left", DATA_W'(got.left), DATA_W'(want.left));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        heap_mirror_step({s_axis_tuser, s_axis_tdata[DATA_W-1:0]});
      end
    end
  end

  always @(negedge clk) begin : driver
    heap_cmd_t next_cmd;
    int burst_left;
    int gap_left;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_axis_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        s_axis_tdata  <= next_cmd.value;
        s_axis_tuser  <= next_cmd.cmd;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int hold_left;
    int holds_served;
    int rx_span;
    int rx_mode;
    if (rst) begin
      hold_left = 0;
      holds_served = 0;
      rx_span = 0;
      rx_mode = 0;
    end
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(8, 64);
      end
      rx_span--;
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic queue_cmd(input logic cmd, input logic [DATA_W-1:0] value);
    heap_cmd_t it;
    it.cmd = cmd;
    it.value = value;
    pending_cmds.push_back(it);
    items_queued++;
  endtask

  task automatic push_value(input logic [DATA_W-1:0] value);
    queue_cmd(CMD_PUSH, value);
  endtask

  task automatic pop_root();
    queue_cmd(CMD_POP, $urandom);
  endtask

  // Waits until every command is taken and every result has come, then lets
  // a full-heap replacement run out before anything else happens.
  task automatic settle();
    while (items_taken != items_queued || expected_pops.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_CAPACITY) begin
      if (heap_count == 0) heap_cap = clip_capacity(data);
    end else if (idx == REG_HEAP_ORDER) begin
      heap_is_max = data[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return DATA_W'($signed($urandom_range(0, 15)) - 8);
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic random_phase(input int n, input int pop_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= pop_pct) begin
        pop_root();
      end else begin
        push_value(pick_value());
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(1);
      2: return '1;
      3: return CFG_W'(MAX_ENTRIES);
      4: return CFG_W'($urandom_range(1, 2047));
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin : stimulus
    int random_items;
    int phase_no;
    int n;
    int pop_pct;
    heap_count = 0;
    heap_cap = clip_capacity(CFG_W'(1024));
    heap_is_max = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: extremes of the value range and pops on an empty heap.
    pop_root();
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(32'h0000_0000);
    push_value(32'hFFFF_FFFF);
    repeat (5) pop_root();
    settle();

    // A capacity of zero keeps one entry; smaller and equal values are dropped.
    write_reg(REG_CAPACITY, '0);
    write_reg(REG_HEAP_ORDER, CFG_W'(0));
    push_value(32'd4);
    push_value(32'd2);
    push_value(32'd4);
    push_value(32'd9);
    pop_root();
    settle();

    write_reg(REG_CAPACITY, CFG_W'(2));
    write_reg(REG_HEAP_ORDER, CFG_W'(1));
    push_value(32'd10);
    push_value(-32'sd5);
    push_value(32'd10);
    push_value(32'd3);
    settle();

    // The heap is not empty, so the capacity write is ignored, and the order
    // change applies to the arrangement left by the other order.
    write_reg(REG_CAPACITY, CFG_W'(1500));
    write_reg(REG_HEAP_ORDER, CFG_W'(0));
    repeat (3) pop_root();

    random_items = 0;
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      write_reg(REG_CAPACITY, pick_capacity());
      write_reg(REG_HEAP_ORDER, CFG_W'($urandom_range(0, 1)));
      n = $urandom_range(20, 60);
      if (phase_no % 5 == 1) begin
        hold_requests++;
        pop_pct = 70;
      end else begin
        case ($urandom_range(0, 3))
          0: pop_pct = 10;
          1: pop_pct = 25;
          2: pop_pct = 45;
          default: pop_pct = 65;
        endcase
      end
      random_phase(n, pop_pct);
      random_items += n;
      if ($urandom_range(0, 3) != 0) begin
        settle();
        n = heap_count + $urandom_range(0, 1);
        repeat (n) pop_root();
        random_items += n;
      end
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
